### hdl/csr_row_dot_product_core_assert.svh
// ----------------------------------------------------------------------------
// csr_row_dot_product_core_assert
// Assertion macros used by the core top level. Clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef CSR_ROW_DOT_PRODUCT_CORE_ASSERT_SVH
`define CSR_ROW_DOT_PRODUCT_CORE_ASSERT_SVH

// same-cycle implication
`define CSRDP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define CSRDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/csrdp_pkg.sv
// ----------------------------------------------------------------------------
// csrdp_pkg
// Shared types and constants of the CSR row dot product core.
// ----------------------------------------------------------------------------
package csrdp_pkg;

	localparam int VECTOR_DEPTH_DEF = 1024;
	localparam int MID_DEPTH        = 4;
	localparam int OUT_DEPTH        = 8;

	localparam int INDEX_W = 10;
	localparam int DATA_W  = 32;
	localparam int ACC_W   = 48;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_ENTRY = 1'b1;

	localparam logic [1:0] MODE_SUM      = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_SUB      = 2'd2;
	localparam logic [1:0] MODE_RESIDUAL = 2'd3;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// work item handed from front to back
	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] elem;
		logic                     has_entry;
		logic                     row_end;
		logic signed [DATA_W-1:0] base;
	} op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] row_result;
		logic                     saturated;
	} res_t;

endpackage

### hdl/csrdp_fifo.sv
// ----------------------------------------------------------------------------
// csrdp_fifo
// Small register-based first-in first-out queue with a fill count.
// ----------------------------------------------------------------------------
module csrdp_fifo
	import csrdp_pkg::*;
#(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/csrdp_front.sv
// ----------------------------------------------------------------------------
// csrdp_front
// Accepts items, writes loads into the vector store, reads the element for
// entries and forwards row work to the back end queue.
// ----------------------------------------------------------------------------
module csrdp_front
	import csrdp_pkg::*;
#(
	parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           func,
	input  logic [INDEX_W-1:0]             index,
	input  logic signed [DATA_W-1:0]       value,
	input  logic                           has_entry,
	input  logic                           row_end,
	input  logic signed [DATA_W-1:0]       row_base,
	input  logic [$clog2(MID_DEPTH+1)-1:0] q_count,
	output logic                           op_valid,
	output op_t                            op
);

	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int IW = (INDEX_W > AW) ? INDEX_W : AW;
	localparam int CW = $clog2(MID_DEPTH+1);

	logic [DATA_W-1:0] mem_q [VECTOR_DEPTH];
	logic [DATA_W-1:0] rd_data_s1;
	logic              valid_s1;
	logic signed [DATA_W-1:0] val_s1;
	logic signed [DATA_W-1:0] base_s1;
	logic              has_s1;
	logic              end_s1;
	logic              inr_s1;

	logic              accept;
	logic              in_range;
	logic [IW-1:0]     idx_ext;
	logic [AW-1:0]     addr;
	logic              is_work;

	// one slot reserved for the item sitting in s1
	assign full     = ((CW+1)'(q_count) + (CW+1)'(valid_s1)) >= (CW+1)'(MID_DEPTH);
	assign accept   = push && !full;
	assign in_range = (32'(index) < 32'(VECTOR_DEPTH));
	assign idx_ext  = IW'(index);
	assign addr     = idx_ext[AW-1:0];
	// idle entries (no nonzero, not a row end) are dropped here
	assign is_work  = (func == FUNC_ENTRY) && (has_entry || row_end);

	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_LOAD) && in_range) begin
			mem_q[addr] <= value;
		end
		if (accept && (func == FUNC_ENTRY)) begin
			rd_data_s1 <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && is_work;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1  <= value;
			base_s1 <= row_base;
			has_s1  <= has_entry;
			end_s1  <= row_end;
			inr_s1  <= in_range;
		end
	end

	assign op_valid     = valid_s1;
	assign op.val       = val_s1;
	assign op.elem      = inr_s1 ? signed'(rd_data_s1) : '0;
	assign op.has_entry = has_s1;
	assign op.row_end   = end_s1;
	assign op.base      = base_s1;

endmodule

### hdl/csrdp_back.sv
// ----------------------------------------------------------------------------
// csrdp_back
// Multiply, saturating row accumulation and combine with the row base.
// Pulls work only when the result queue has room for all rows in flight.
// ----------------------------------------------------------------------------
module csrdp_back
	import csrdp_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [1:0]                     combine_mode,
	input  logic                           op_empty,
	input  op_t                            op,
	output logic                           op_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           res_push,
	output res_t                           res
);

	localparam int CW = $clog2(OUT_DEPTH+1) + 2;

	logic                     v_s1;
	logic                     end_s1;
	logic signed [ACC_W-1:0]  prod_s1;
	logic signed [DATA_W-1:0] base_s1;

	logic                     v_s2;
	logic signed [ACC_W-1:0]  sum_s2;
	logic                     clip_s2;
	logic signed [DATA_W-1:0] base_s2;

	logic                     v_s3;
	logic signed [DATA_W-1:0] res_s3;
	logic                     sat_s3;

	logic signed [ACC_W-1:0]  acc_q;
	logic                     clip_q;

	logic [CW-1:0]            pending;
	logic signed [2*DATA_W-1:0] prod_full;
	logic signed [ACC_W:0]    acc_sum;
	logic                     acc_ovf;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W+1:0]  comb;
	logic signed [ACC_W+1:0]  sum_ext;
	logic signed [ACC_W+1:0]  base_ext;
	logic                     res_ovf;

	assign pending = CW'(out_count) + CW'(v_s1 && end_s1) + CW'(v_s2) + CW'(v_s3);
	assign op_pop  = !op_empty && (pending < CW'(OUT_DEPTH));

	// s1: exact Q32.32 product, floor to Q32.16
	assign prod_full = op.val * op.elem;

	always_ff @(posedge clk) begin
		if (op_pop) begin
			prod_s1 <= op.has_entry ? prod_full[2*DATA_W-1:16] : '0;
			end_s1  <= op.row_end;
			base_s1 <= op.base;
		end
	end

	// s2: accumulator with clamp
	assign acc_sum  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_s1);
	assign acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];
	assign acc_next = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else begin
			v_s1 <= op_pop;
			v_s2 <= v_s1 && end_s1;
			v_s3 <= v_s2;
			if (v_s1) begin
				if (end_s1) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= acc_next;
					clip_q <= clip_q || acc_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && end_s1) begin
			sum_s2  <= acc_next;
			clip_s2 <= clip_q || acc_ovf;
			base_s2 <= base_s1;
		end
	end

	// s3: combine and clamp to 32 bits
	assign sum_ext  = (ACC_W+2)'(sum_s2);
	assign base_ext = (ACC_W+2)'(base_s2);

	always_comb begin
		case (combine_mode)
			MODE_SUM:      comb = sum_ext;
			MODE_ADD:      comb = base_ext + sum_ext;
			MODE_SUB:      comb = base_ext - sum_ext;
			MODE_RESIDUAL: comb = base_ext - sum_ext;
			default:       comb = sum_ext;
		endcase
	end

	assign res_ovf = !((comb[ACC_W+1:DATA_W-1] == '0) || (comb[ACC_W+1:DATA_W-1] == '1));

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (res_ovf) begin
				res_s3 <= comb[ACC_W+1] ? {1'b1, {(DATA_W-1){1'b0}}}
				                        : {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				res_s3 <= comb[DATA_W-1:0];
			end
			sat_s3 <= clip_s2 || res_ovf;
		end
	end

	assign res_push       = v_s3;
	assign res.row_result = res_s3;
	assign res.saturated  = sat_s3;

endmodule

### hdl/csr_row_dot_product_core.sv
// ----------------------------------------------------------------------------
// csr_row_dot_product_core
// Compressed-row sparse matrix times dense vector, Q16.16, one row result
// per row end, saturating.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        func, index, value, has_entry, row_end, row_base
//  result    pop / empty        row_result, saturated
//  config    cfg_wr_en          cfg_wr_data (combine mode)
//
// One item per cycle sustained while full is low; the back end does one
// multiply-accumulate per cycle while pulling work, on a single 48-bit adder
// feedback. No clearing pass after reset: the vector store is valid only where
// written. When the result queue fills, the back end stops pulling work, the
// middle queue fills and full rises.
`include "csr_row_dot_product_core_assert.svh"

module csr_row_dot_product_core
	import csrdp_pkg::*;
#(
	parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     func,
	input  logic [INDEX_W-1:0]       index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     has_entry,
	input  logic                     row_end,
	input  logic signed [DATA_W-1:0] row_base,
	input  logic                     pop,
	output logic                     empty,
	output logic signed [DATA_W-1:0] row_result,
	output logic                     saturated,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_wr_data
);

	logic [1:0] mode_q;

	logic                           fe_valid;
	op_t                            fe_op;
	op_t                            mid_op;
	logic                           mid_empty;
	logic                           mid_full;
	logic                           mid_pop;
	logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

	logic                           be_push;
	res_t                           be_res;
	res_t                           out_res;
	logic                           out_full;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUM;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	csrdp_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.index    (index),
		.value    (value),
		.has_entry(has_entry),
		.row_end  (row_end),
		.row_base (row_base),
		.q_count  (mid_count),
		.op_valid (fe_valid),
		.op       (fe_op)
	);

	csrdp_fifo #(
		.DEPTH(MID_DEPTH),
		.WIDTH($bits(op_t))
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fe_valid),
		.wr_data(fe_op),
		.rd_en  (mid_pop),
		.rd_data(mid_op),
		.empty  (mid_empty),
		.full   (mid_full),
		.count  (mid_count)
	);

	csrdp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.combine_mode(mode_q),
		.op_empty    (mid_empty),
		.op          (mid_op),
		.op_pop      (mid_pop),
		.out_count   (out_count),
		.res_push    (be_push),
		.res         (be_res)
	);

	csrdp_fifo #(
		.DEPTH(OUT_DEPTH),
		.WIDTH($bits(res_t))
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (be_push),
		.wr_data(be_res),
		.rd_en  (pop),
		.rd_data(out_res),
		.empty  (empty),
		.full   (out_full),
		.count  (out_count)
	);

	assign row_result = out_res.row_result;
	assign saturated  = out_res.saturated;

	`CSRDP_ASSERT_NOW(a_mid_no_overflow, fe_valid, !mid_full, "work queue overflow")
	`CSRDP_ASSERT_NOW(a_out_no_overflow, be_push, !out_full, "result queue overflow")
	`CSRDP_ASSERT_NEXT(a_load_not_queued, push && !full && (func == FUNC_LOAD),
		!fe_valid, "load item forwarded to back end")

endmodule

### dv/csr_row_dot_product_checker.sv
// ----------------------------------------------------------------------------
// csr_row_dot_product_checker
// Watches the item, result and mode-write ports of the CSR row dot product
// core, keeps its own copy of the vector store, row accumulator and combine
// mode, and compares every popped row result with the predicted one.
// ----------------------------------------------------------------------------
module csr_row_dot_product_checker
	import csrdp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     full,
	input  logic                     func,
	input  logic [INDEX_W-1:0]       index,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     has_entry,
	input  logic                     row_end,
	input  logic signed [DATA_W-1:0] row_base,
	input  logic                     pop,
	input  logic                     empty,
	input  logic signed [DATA_W-1:0] row_result,
	input  logic                     saturated,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_wr_data,
	output int                       mismatch_count,
	output int                       rows_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [63:0] RES_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] RES_MIN = -RES_MAX - 64'sd1;

	logic signed [DATA_W-1:0] vec_mem [VECTOR_DEPTH_DEF];
	logic signed [ACC_W-1:0]  row_acc;
	logic                     row_clip;
	logic [1:0]               mode;
	res_t                     expected_rows [$];

	logic signed [63:0] mac_prod;
	logic signed [63:0] mac_sum;
	logic signed [63:0] combined;
	res_t               row_want;
	res_t               row_got;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VECTOR_DEPTH_DEF; i++)
				vec_mem[i] = '0;
			row_acc = '0;
			row_clip = 1'b0;
			mode = MODE_SUM;
			expected_rows.delete();
			mismatch_count = 0;
			rows_pending = 0;
		end else begin
			if (cfg_wr_en)
				mode = cfg_wr_data;

			// result side first: a row accepted this edge cannot already be out
			if (pop && !empty) begin
				row_got.row_result = row_result;
				row_got.saturated = saturated;
				if (expected_rows.size() == 0) begin
					mismatch_count++;
					$display("%0t: row result %h sat %b with no row pending",
						$time, row_got.row_result, row_got.saturated);
				end else begin
					row_want = expected_rows.pop_front();
					if (row_got.row_result !== row_want.row_result) begin
						mismatch_count++;
						$display("%0t: row_result expected %h got %h", $time,
							row_want.row_result, row_got.row_result);
					end
					if (row_got.saturated !== row_want.saturated) begin
						mismatch_count++;
						$display("%0t: saturated expected %b got %b", $time,
							row_want.saturated, row_got.saturated);
					end
				end
			end

			if (push && !full) begin
				if (func == FUNC_LOAD) begin
					vec_mem[index] = value;
				end else begin
					if (has_entry) begin
						// Q32.32 product floored back to Q32.16
						mac_prod = value * vec_mem[index];
						mac_prod = mac_prod >>> 16;
						mac_sum = row_acc + mac_prod;
						if (mac_sum > ACC_MAX) begin
							mac_sum = ACC_MAX;
							row_clip = 1'b1;
						end else if (mac_sum < ACC_MIN) begin
							mac_sum = ACC_MIN;
							row_clip = 1'b1;
						end
						row_acc = mac_sum[ACC_W-1:0];
					end
					if (row_end) begin
						case (mode)
							MODE_SUM: combined = row_acc;
							MODE_ADD: combined = row_base + row_acc;
							default:  combined = row_base - row_acc;
						endcase
						row_want.saturated = row_clip;
						if (combined > RES_MAX) begin
							combined = RES_MAX;
							row_want.saturated = 1'b1;
						end else if (combined < RES_MIN) begin
							combined = RES_MIN;
							row_want.saturated = 1'b1;
						end
						row_want.row_result = combined[DATA_W-1:0];
						expected_rows.push_back(row_want);
						row_acc = '0;
						row_clip = 1'b0;
					end
				end
			end

			rows_pending = expected_rows.size();
		end
	end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives vector loads and sparse row entries into the CSR row dot product
// core: a directed pass over the arithmetic corners and every combine mode,
// then random rows under changing modes and backpressure profiles.
// ----------------------------------------------------------------------------
module tb_top;
	import csrdp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_PAUSE = 12;
	localparam int CHUNK_ITEMS = 68;
	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic [INDEX_W-1:0] LAST_COL = INDEX_W'(VECTOR_DEPTH_DEF - 1);

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic                     func = FUNC_LOAD;
	logic [INDEX_W-1:0]       index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     has_entry = 1'b0;
	logic                     row_end = 1'b0;
	logic signed [DATA_W-1:0] row_base = '0;
	logic                     pop = 1'b0;
	logic                     empty;
	logic signed [DATA_W-1:0] row_result;
	logic                     saturated;
	logic                     cfg_wr_en = 1'b0;
	logic [1:0]               cfg_wr_data = MODE_SUM;

	int mismatch_count;
	int rows_pending;
	int tx_idle_pct = 6;
	int rx_idle_pct = 88;
	int stall_cycles = 0;

	bit                 written [VECTOR_DEPTH_DEF];
	logic [INDEX_W-1:0] written_cols [$];

	always #5 clk = ~clk;

	csr_row_dot_product_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.index       (index),
		.value       (value),
		.has_entry   (has_entry),
		.row_end     (row_end),
		.row_base    (row_base),
		.pop         (pop),
		.empty       (empty),
		.row_result  (row_result),
		.saturated   (saturated),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	csr_row_dot_product_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.func           (func),
		.index          (index),
		.value          (value),
		.has_entry      (has_entry),
		.row_end        (row_end),
		.row_base       (row_base),
		.pop            (pop),
		.empty          (empty),
		.row_result     (row_result),
		.saturated      (saturated),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mismatch_count (mismatch_count),
		.rows_pending   (rows_pending)
	);

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// mostly small Q16.16 values, with extremes and full-range words mixed in
	function automatic logic signed [DATA_W-1:0] rand_q();
		case ($urandom_range(9))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2, 3:    return $urandom;
			default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic drive_item(input logic f, input logic [INDEX_W-1:0] idx,
		input logic signed [DATA_W-1:0] val, input logic he, input logic re,
		input logic signed [DATA_W-1:0] base);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		func <= f;
		index <= idx;
		value <= val;
		has_entry <= he;
		row_end <= re;
		row_base <= base;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	// row flags and base are don't-care on a load, so randomize them
	task automatic load_elem(input logic [INDEX_W-1:0] idx,
		input logic signed [DATA_W-1:0] val);
		drive_item(FUNC_LOAD, idx, val, 1'($urandom), 1'($urandom), $urandom);
		if (!written[idx]) begin
			written[idx] = 1'b1;
			written_cols.push_back(idx);
		end
	endtask

	task automatic add_entry(input logic [INDEX_W-1:0] col,
		input logic signed [DATA_W-1:0] val, input logic re,
		input logic signed [DATA_W-1:0] base);
		drive_item(FUNC_ENTRY, col, val, 1'b1, re, base);
	endtask

	// entry item without a nonzero: closes the row, or does nothing if re is 0
	task automatic no_entry(input logic re, input logic signed [DATA_W-1:0] base);
		drive_item(FUNC_ENTRY, 10'($urandom), $urandom, 1'b0, re, base);
	endtask

	// mode write only once the core has drained
	task automatic set_mode(input logic [1:0] m, input int tx_pct, input int rx_pct);
		push <= 1'b0;
		tx_idle_pct <= tx_pct;
		rx_idle_pct <= rx_pct;
		while (rows_pending != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_rows(input int n_items);
		int done;
		int n_ent;
		bit tail_term;
		done = 0;
		while (done < n_items) begin
			n_ent = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
			tail_term = (n_ent == 0) || ($urandom_range(4) == 0);
			for (int e = 0; e < n_ent; e++) begin
				if ($urandom_range(99) < 15) begin
					load_elem(10'($urandom_range(VECTOR_DEPTH_DEF - 1)), rand_q());
					done++;
				end
				if ($urandom_range(99) < 5)
					no_entry(1'b0, $urandom);
				add_entry(written_cols[$urandom_range(written_cols.size() - 1)],
					rand_q(), (e == n_ent - 1) && !tail_term, rand_q());
				done++;
			end
			if (tail_term) begin
				no_entry(1'b1, rand_q());
				done++;
			end
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_mode(MODE_SUM, 6, 88);
		load_elem(10'd0, Q_MAX);
		load_elem(LAST_COL, Q_MIN);
		load_elem(10'd5, Q_ONE);
		load_elem(10'd6, -Q_ONE);
		load_elem(10'd7, 32'sh0000_0001);
		add_entry(10'd5, 32'sh0002_8000, 1'b0, $urandom);
		add_entry(10'd6, Q_ONE, 1'b1, $urandom);
		no_entry(1'b1, $urandom);
		no_entry(1'b0, $urandom);
		// two min*min products overflow the accumulator
		add_entry(LAST_COL, Q_MIN, 1'b0, $urandom);
		add_entry(LAST_COL, Q_MIN, 1'b1, $urandom);
		add_entry(10'd0, Q_MAX, 1'b1, $urandom);
		// tiny negative product floors to -1 lsb
		add_entry(10'd7, -32'sd1, 1'b1, $urandom);
		add_entry(10'd0, Q_MIN, 1'b0, $urandom);
		add_entry(10'd0, Q_MIN, 1'b0, $urandom);
		add_entry(LAST_COL, Q_MAX, 1'b1, $urandom);

		set_mode(MODE_ADD, 6, 88);
		add_entry(10'd5, Q_ONE, 1'b1, Q_MAX);
		set_mode(MODE_SUB, 6, 88);
		add_entry(10'd5, Q_ONE, 1'b1, Q_MIN);
		set_mode(MODE_RESIDUAL, 6, 88);
		add_entry(10'd6, Q_ONE, 1'b1, Q_MAX);
		no_entry(1'b1, Q_MIN);

		for (int k = 0; k < 6; k++) begin
			case (k % 4)
				0: set_mode(MODE_ADD, k < 2 ? 6 : (k < 4 ? 88 : 0), k < 2 ? 88 : (k < 4 ? 6 : 0));
				1: set_mode(MODE_SUB, k < 2 ? 6 : (k < 4 ? 88 : 0), k < 2 ? 88 : (k < 4 ? 6 : 0));
				2: set_mode(MODE_RESIDUAL, k < 2 ? 6 : (k < 4 ? 88 : 0),
					k < 2 ? 88 : (k < 4 ? 6 : 0));
				default: set_mode(MODE_SUM, k < 2 ? 6 : (k < 4 ? 88 : 0),
					k < 2 ? 88 : (k < 4 ? 6 : 0));
			endcase
			random_rows(CHUNK_ITEMS);
		end

		push <= 1'b0;
		while (rows_pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
